FILE: hw/rtl/ppi_pkg.sv
// Shared types, widths and register codes of the positional/incremental PID controller.
package ppi_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int GAIN_W     = 16;
    localparam int SETPOINT_W = 16;
    localparam int DRIVE_W    = 16;
    localparam int DLIM_W     = 15;
    localparam int ALIM_W     = 23;
    localparam int ACC_W      = ALIM_W + 1;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_W     = REG_IDX_W + 2;

    localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST = '1;
    localparam logic [ALIM_W-1:0] ACCUM_LIMIT_RST = '1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_SETPOINT    = 3'd3,
        REG_LOOP_MODE   = 3'd4,
        REG_DRIVE_LIMIT = 3'd5,
        REG_ACCUM_LIMIT = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_loop_mode;

    typedef struct packed {
        logic signed [GAIN_W-1:0]     gain_p;
        logic signed [GAIN_W-1:0]     gain_i;
        logic signed [GAIN_W-1:0]     gain_d;
        logic signed [SETPOINT_W-1:0] setpoint;
        t_loop_mode                   loop_mode;
        logic [DLIM_W-1:0]            drive_limit;
        logic [ALIM_W-1:0]            accum_limit;
    } t_cfg;

endpackage

FILE: hw/rtl/ppi_cfg.sv
// APB register file holding the gains, setpoint, mode and saturation limits.
module ppi_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppi_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppi_pkg::DATA_W-1:0]   pwdata,
    output logic [ppi_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output ppi_pkg::t_cfg                o_cfg
);
    import ppi_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.setpoint    <= '0;
            r_cfg.loop_mode   <= MODE_POSITIONAL;
            r_cfg.drive_limit <= DRIVE_LIMIT_RST;
            r_cfg.accum_limit <= ACCUM_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:      r_cfg.gain_p      <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:      r_cfg.gain_i      <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:      r_cfg.gain_d      <= pwdata[GAIN_W-1:0];
                REG_SETPOINT:    r_cfg.setpoint    <= pwdata[SETPOINT_W-1:0];
                REG_LOOP_MODE:   r_cfg.loop_mode   <= t_loop_mode'(pwdata[0]);
                REG_DRIVE_LIMIT: r_cfg.drive_limit <= pwdata[DLIM_W-1:0];
                REG_ACCUM_LIMIT: r_cfg.accum_limit <= pwdata[ALIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_GAIN_P:      prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain_p};
            REG_GAIN_I:      prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain_i};
            REG_GAIN_D:      prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain_d};
            REG_SETPOINT:    prdata = {{(DATA_W-SETPOINT_W){1'b0}}, r_cfg.setpoint};
            REG_LOOP_MODE:   prdata = {{(DATA_W-1){1'b0}}, r_cfg.loop_mode};
            REG_DRIVE_LIMIT: prdata = {{(DATA_W-DLIM_W){1'b0}}, r_cfg.drive_limit};
            REG_ACCUM_LIMIT: prdata = {{(DATA_W-ALIM_W){1'b0}}, r_cfg.accum_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/ppi_core.sv
// PID datapath: error history, integral and held output, with the drive for one sample.
module ppi_core #(
    parameter int SAMPLE_WIDTH   = ppi_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppi_pkg::t_cfg                       i_cfg,
    input  logic                                i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    output logic signed [ppi_pkg::DRIVE_W-1:0]  o_drive
);
    import ppi_pkg::*;

    localparam int IN_W  = (SAMPLE_WIDTH > SETPOINT_W) ? SAMPLE_WIDTH : SETPOINT_W;
    localparam int EW    = IN_W + 1;                            // error
    localparam int DW    = EW + 2;                              // error differences
    localparam int ASW   = ((ACC_W > EW) ? ACC_W : EW) + 1;     // integral before clamp
    localparam int MW    = (DW > ACC_W) ? DW : ACC_W;           // multiplier operand
    localparam int PW    = GAIN_W + MW;                         // product
    localparam int TW    = PW + 2;                              // sum of terms

    logic signed [EW-1:0]      r_last_err;
    logic signed [EW-1:0]      r_older_err;
    logic signed [ACC_W-1:0]   r_err_sum;
    logic signed [DRIVE_W-1:0] r_held;

    logic signed [EW-1:0]      w_err;
    logic signed [DW-1:0]      w_diff1;
    logic signed [DW-1:0]      w_diff2;
    logic signed [ASW-1:0]     w_acc_raw;
    logic signed [ASW-1:0]     w_alim;
    logic signed [ACC_W-1:0]   w_acc_next;
    logic signed [MW-1:0]      w_op_p;
    logic signed [MW-1:0]      w_op_i;
    logic signed [MW-1:0]      w_op_d;
    logic signed [PW-1:0]      w_prod_p;
    logic signed [PW-1:0]      w_prod_i;
    logic signed [PW-1:0]      w_prod_d;
    logic signed [TW-1:0]      w_held_add;
    logic signed [TW-1:0]      w_total;
    logic signed [TW-1:0]      w_dlim;
    logic                      w_incr;

    assign w_incr = (i_cfg.loop_mode == MODE_INCREMENTAL);

    assign w_err   = EW'(i_cfg.setpoint) - EW'(i_sample);
    assign w_diff1 = DW'(w_err) - DW'(r_last_err);
    assign w_diff2 = DW'(w_err) - (DW'(r_last_err) <<< 1) + DW'(r_older_err);

    // Integral update with symmetric clamp; only committed in positional form.
    assign w_acc_raw = ASW'(r_err_sum) + ASW'(w_err);
    assign w_alim    = ASW'({1'b0, i_cfg.accum_limit});

    always_comb begin
        if (w_acc_raw > w_alim) begin
            w_acc_next = ACC_W'(w_alim);
        end else if (w_acc_raw < -w_alim) begin
            w_acc_next = ACC_W'(-w_alim);
        end else begin
            w_acc_next = ACC_W'(w_acc_raw);
        end
    end

    // The three multipliers are shared between forms by selecting their operands.
    assign w_op_p = w_incr ? MW'(w_diff1) : MW'(w_err);
    assign w_op_i = w_incr ? MW'(w_err)   : MW'(w_acc_next);
    assign w_op_d = w_incr ? MW'(w_diff2) : MW'(w_diff1);

    assign w_prod_p = PW'(i_cfg.gain_p) * PW'(w_op_p);
    assign w_prod_i = PW'(i_cfg.gain_i) * PW'(w_op_i);
    assign w_prod_d = PW'(i_cfg.gain_d) * PW'(w_op_d);

    assign w_held_add = w_incr ? TW'(r_held) : '0;
    assign w_total = TW'(w_prod_p >>> GAIN_FRAC_BITS) + TW'(w_prod_i >>> GAIN_FRAC_BITS)
                   + TW'(w_prod_d >>> GAIN_FRAC_BITS) + w_held_add;
    assign w_dlim  = TW'({1'b0, i_cfg.drive_limit});

    always_comb begin
        if (w_total > w_dlim) begin
            o_drive = DRIVE_W'(w_dlim);
        end else if (w_total < -w_dlim) begin
            o_drive = DRIVE_W'(-w_dlim);
        end else begin
            o_drive = DRIVE_W'(w_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_older_err <= '0;
            r_err_sum   <= '0;
            r_held      <= '0;
        end else if (i_advance) begin
            r_last_err <= w_err;
            if (w_incr) begin
                r_older_err <= r_last_err;
                r_held      <= o_drive;
            end else begin
                r_err_sum   <= w_acc_next;
            end
        end
    end

endmodule

FILE: hw/rtl/pid_position_incremental.sv
// Top level of the positional/incremental PID controller with APB configuration.
//
// Each sample word taken on the input channel yields exactly one drive word on
// the output channel. A sample is first captured in an input register; once the
// output register is empty or is being emptied, the error, the integral or
// incremental update, the three gain products and both saturations are computed in
// one pass and the drive is loaded into the output register while the history
// state is updated at the same edge. The drive word passes the input register and
// then the output register before it is valid. A new sample word is accepted every
// cycle as long as the output side keeps taking words; the output register lets
// the next sample enter while a finished drive word is still waiting. Throughput
// is one word per cycle while the output side keeps taking words, set by the
// single stage of three parallel 16-bit-gain multipliers. Configuration registers
// (byte address 4*index: gain_p, gain_i, gain_d, setpoint, loop_mode, drive_limit,
// accum_limit) should be written only while no sample is in flight. Switching
// loop_mode keeps the error history, integral and held output.
module pid_position_incremental #(
    parameter int SAMPLE_WIDTH   = ppi_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppi_pkg::ADDR_W-1:0]          paddr,
    input  logic [ppi_pkg::DATA_W-1:0]          pwdata,
    output logic [ppi_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // Sample input channel
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    // Drive output channel
    output logic                                o_drive_valid,
    input  logic                                i_drive_ready,
    output logic signed [ppi_pkg::DRIVE_W-1:0]  o_drive
);
    import ppi_pkg::*;

    t_cfg                          w_cfg;
    logic                          r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                          r_out_valid;
    logic signed [DRIVE_W-1:0]     r_drive;
    logic signed [DRIVE_W-1:0]     w_drive;
    logic                          w_advance;

    ppi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppi_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_advance),
        .i_sample  (r_sample),
        .o_drive   (w_drive)
    );

    // The captured sample moves on whenever the output register is empty or is
    // being emptied in this cycle; the controller state advances with it.
    assign w_advance      = r_in_valid & (~r_out_valid | i_drive_ready);
    assign o_sample_ready = ~r_in_valid | w_advance;

    assign o_drive_valid = r_out_valid;
    assign o_drive       = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_sample_ready) begin
                r_in_valid <= i_sample_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_drive_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample_valid & o_sample_ready) begin
            r_sample <= i_sample;
        end
        if (w_advance) begin
            r_drive <= w_drive;
        end
    end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the positional/incremental PID controller.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppi_pkg::*;

    localparam int FRAC_BITS       = GAIN_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int LONG_STALL      = 250;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 120;
    localparam int SETTLE_CYCLES   = 4;

    // Index seven has no register behind it; a write there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // How often a side of the handshake pauses between words.
    typedef enum int {
        IDLE_NONE,
        IDLE_SOME,
        IDLE_FULL
    } t_idle_style;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       i_sample_valid = 1'b0;
    logic                       o_sample_ready;
    logic signed [15:0]         i_sample = '0;
    logic                       o_drive_valid;
    logic                       i_drive_ready = 1'b0;
    logic signed [DRIVE_W-1:0]  o_drive;

    // Expected controller state and configuration, kept at the block's widths.
    logic signed [GAIN_W-1:0]     kp = '0;
    logic signed [GAIN_W-1:0]     ki = '0;
    logic signed [GAIN_W-1:0]     kd = '0;
    logic signed [SETPOINT_W-1:0] target = '0;
    t_loop_mode                   form = MODE_POSITIONAL;
    logic [DLIM_W-1:0]            out_lim = DRIVE_LIMIT_RST;
    logic [ALIM_W-1:0]            sum_lim = ACCUM_LIMIT_RST;
    logic signed [16:0]           last_err = '0;
    logic signed [16:0]           older_err = '0;
    logic signed [ACC_W-1:0]      err_sum = '0;
    logic signed [DRIVE_W-1:0]    held = '0;

    logic signed [15:0]         samples_to_send[$];
    logic signed [DRIVE_W-1:0]  drive_expected[$];

    t_idle_style  send_style = IDLE_NONE;
    t_idle_style  recv_style = IDLE_NONE;
    int unsigned  send_wait = 0;
    int unsigned  recv_wait = 0;
    int unsigned  stall_left = 0;
    logic         stall_req = 1'b0;
    logic         stall_ack = 1'b0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;

    pid_position_incremental dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_drive_valid  (o_drive_valid),
        .i_drive_ready  (i_drive_ready),
        .o_drive        (o_drive)
    );

    always #5 i_clk = ~i_clk;

    // The run is cut off here if the block ever stops moving words.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint saturate(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Advances the expected loop state by one sample and returns the drive word
    // the block should produce for it. Every product is formed exactly and then
    // shifted arithmetically, which rounds toward minus infinity.
    function automatic logic signed [DRIVE_W-1:0] advance_loop(input logic signed [15:0] meas);
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        err = longint'(target) - longint'(meas);
        if (form == MODE_POSITIONAL) begin
            // The integral saturates before it is weighted; older_err and the
            // held output are left alone in this form.
            err_sum = ACC_W'(saturate(longint'(err_sum) + err, longint'(sum_lim)));
            p_term = (longint'(kp) * err) >>> FRAC_BITS;
            i_term = (longint'(ki) * longint'(err_sum)) >>> FRAC_BITS;
            d_term = (longint'(kd) * (err - longint'(last_err))) >>> FRAC_BITS;
            total = saturate(p_term + i_term + d_term, longint'(out_lim));
            last_err = 17'(err);
            return DRIVE_W'(total);
        end else begin
            // The incremental form moves the held output and never touches the
            // integral, so a later switch back finds it where it was.
            p_term = (longint'(kp) * (err - longint'(last_err))) >>> FRAC_BITS;
            i_term = (longint'(ki) * err) >>> FRAC_BITS;
            d_term = (longint'(kd) * (err - 2 * longint'(last_err) + longint'(older_err)))
                     >>> FRAC_BITS;
            older_err = last_err;
            last_err = 17'(err);
            held = DRIVE_W'(saturate(longint'(held) + p_term + i_term + d_term,
                                     longint'(out_lim)));
            return held;
        end
    endfunction

    function automatic int unsigned draw_gap(input t_idle_style style);
        case (style)
            IDLE_FULL: return $urandom_range(0, 15);
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            default:   return 0;
        endcase
    endfunction

    // Sender: a word stays on the bus until it is taken; the expected drive is
    // worked out at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else begin
            if (i_sample_valid && o_sample_ready)
                drive_expected.push_back(advance_loop(i_sample));
            if (!i_sample_valid || o_sample_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    i_sample_valid <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    i_sample <= samples_to_send.pop_front();
                    i_sample_valid <= 1'b1;
                    send_wait = draw_gap(send_style);
                end else begin
                    i_sample_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every drive word against the oldest expectation and
    // throttles ready. A long hold-off is requested by toggling stall_req and
    // is counted down here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_drive_ready <= 1'b0;
        end else begin
            if (o_drive_valid && i_drive_ready) begin
                if (drive_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: drive word %0d arrived with nothing expected",
                             $time, o_drive);
                end else if (o_drive !== drive_expected[0]) begin
                    mismatches++;
                    $display("%0t: drive mismatch, expected %0d, actual %0d",
                             $time, drive_expected[0], o_drive);
                    void'(drive_expected.pop_front());
                end else begin
                    void'(drive_expected.pop_front());
                end
                recv_wait = draw_gap(recv_style);
            end
            if (stall_req != stall_ack) begin
                stall_ack = stall_req;
                stall_left = LONG_STALL;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_drive_ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                i_drive_ready <= 1'b0;
            end else begin
                i_drive_ready <= 1'b1;
            end
        end
    end

    // One APB write: a setup cycle, then an access cycle. The register takes
    // the value at the edge that ends the access cycle, and the expected
    // configuration follows with the same masking of unused upper bits.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] word);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAIN_P:      kp = word[GAIN_W-1:0];
            REG_GAIN_I:      ki = word[GAIN_W-1:0];
            REG_GAIN_D:      kd = word[GAIN_W-1:0];
            REG_SETPOINT:    target = word[SETPOINT_W-1:0];
            REG_LOOP_MODE:   form = t_loop_mode'(word[0]);
            REG_DRIVE_LIMIT: out_lim = word[DLIM_W-1:0];
            REG_ACCUM_LIMIT: sum_lim = word[ALIM_W-1:0];
            default: ;
        endcase
    endtask

    // Returns once every queued sample has gone in and every drive word has
    // come back, then waits on so the pipeline is surely empty.
    task automatic wait_drained();
        @(negedge i_clk);
        while (samples_to_send.size() != 0 || i_sample_valid || drive_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random upper bits ride along on every write so that ignored bits are
    // exercised all the time.
    function automatic logic [DATA_W-1:0] with_noise(input logic [DATA_W-1:0] field,
                                                     input int width);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] keep;
        word = $urandom();
        keep = (DATA_W'(1) << width) - 1;
        return (word & ~keep) | (field & keep);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_W'($urandom());
            1:       return 16'sh7FFF;
            2:       return 16'sh8000;
            3:       return GAIN_W'(int'($urandom_range(0, 1200)) - 600);
            default: return GAIN_W'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [DLIM_W-1:0] pick_drive_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DRIVE_LIMIT_RST;
            2:       return DLIM_W'($urandom_range(1, 255));
            default: return DLIM_W'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [ALIM_W-1:0] pick_accum_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ACCUM_LIMIT_RST;
            2:       return ALIM_W'($urandom_range(1, 4000));
            default: return ALIM_W'($urandom());
        endcase
    endfunction

    initial begin
        int jitter;
        int spread;
        logic signed [15:0] s;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: all gains zero, so the drive must stay zero.
        @(negedge i_clk);
        send_style = IDLE_SOME;
        recv_style = IDLE_SOME;
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh7FFF);
        wait_drained();

        // Extreme gains and setpoint, limits written with all bits set so the
        // bits above each register's width must be dropped, plus a write to
        // the unmapped index that must have no effect.
        cfg_write(REG_GAIN_P, 32'hABCD_7FFF);
        cfg_write(REG_GAIN_I, 32'h1234_8000);
        cfg_write(REG_GAIN_D, 32'hFFFF_0100);
        cfg_write(REG_SETPOINT, 32'h5A5A_7FFF);
        cfg_write(REG_LOOP_MODE, 32'hFFFF_FFFE);
        cfg_write(REG_DRIVE_LIMIT, 32'hFFFF_FFFF);
        cfg_write(REG_ACCUM_LIMIT, 32'hFFFF_FFFF);
        cfg_write(REG_UNMAPPED, $urandom());
        @(negedge i_clk);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh0000);
        samples_to_send.push_back(16'sh5555);
        samples_to_send.push_back(16'shAAAA);
        wait_drained();

        // Switch to the incremental form; history from above carries over.
        cfg_write(REG_LOOP_MODE, 32'h8000_0001);
        @(negedge i_clk);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh0000);
        samples_to_send.push_back(16'shFFFF);
        wait_drained();

        // Zero limits force both the integral and the drive to zero.
        cfg_write(REG_DRIVE_LIMIT, 32'h0000_8000);
        cfg_write(REG_ACCUM_LIMIT, 32'h0080_0000);
        cfg_write(REG_LOOP_MODE, 32'h0000_0000);
        @(negedge i_clk);
        samples_to_send.push_back(16'sd100);
        samples_to_send.push_back(-16'sd100);
        samples_to_send.push_back(16'sh7FFF);
        wait_drained();
        cfg_write(REG_LOOP_MODE, 32'h0000_0001);
        @(negedge i_clk);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh1234);
        wait_drained();

        // Smallest nonzero limits with the most negative gains and setpoint.
        cfg_write(REG_DRIVE_LIMIT, 32'h0000_0001);
        cfg_write(REG_ACCUM_LIMIT, 32'h0000_0001);
        cfg_write(REG_GAIN_P, 32'h0000_8000);
        cfg_write(REG_GAIN_I, 32'h0000_8000);
        cfg_write(REG_GAIN_D, 32'h0000_8000);
        cfg_write(REG_SETPOINT, 32'h0000_8000);
        cfg_write(REG_LOOP_MODE, 32'h0000_0000);
        @(negedge i_clk);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh0001);
        samples_to_send.push_back(16'sh8001);
        wait_drained();

        // Random phases. Most samples sit near the setpoint so the integral and
        // the held output wander instead of pinning at a limit at once; the
        // rest are full-range noise. Handshake pacing changes each phase, and
        // one phase has the receiver hold off while the sender keeps pushing.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cfg_write(REG_GAIN_P, with_noise(DATA_W'(pick_gain()), GAIN_W));
            cfg_write(REG_GAIN_I, with_noise(DATA_W'(pick_gain()), GAIN_W));
            cfg_write(REG_GAIN_D, with_noise(DATA_W'(pick_gain()), GAIN_W));
            cfg_write(REG_SETPOINT, $urandom());
            cfg_write(REG_LOOP_MODE, $urandom());
            cfg_write(REG_DRIVE_LIMIT, with_noise(DATA_W'(pick_drive_limit()), DLIM_W));
            cfg_write(REG_ACCUM_LIMIT, with_noise(DATA_W'(pick_accum_limit()), ALIM_W));
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNMAPPED, $urandom());

            @(negedge i_clk);
            if (ph == 0) begin
                send_style = IDLE_NONE;
                recv_style = IDLE_NONE;
            end else if (ph == 2) begin
                send_style = IDLE_NONE;
                recv_style = IDLE_SOME;
                stall_req <= ~stall_req;
            end else begin
                send_style = t_idle_style'($urandom_range(0, 2));
                recv_style = t_idle_style'($urandom_range(0, 2));
            end

            spread = (ph % 3 == 0) ? 4096 : 256;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    s = 16'($urandom());
                end else begin
                    jitter = int'($urandom_range(0, 2 * spread)) - spread;
                    s = 16'(int'(target) + jitter);
                end
                samples_to_send.push_back(s);
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
